### sv/pcx_rle_pkg.sv
// ----------------------------------------------------------------------------
// PCX run-length decoder package
// Shared constants and types for the scanline decoder.
// ----------------------------------------------------------------------------
package pcx_rle_pkg;

    // Run header marking and count extraction
    localparam logic [7:0] RUN_MARK = 8'hC0;
    localparam logic [5:0] RUN_MASK = 6'h3F;

    // Field widths
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned DIM_W  = 16;
    localparam int unsigned CHAN_W = 2;
    localparam int unsigned RUN_W  = 6;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_LINE_BYTES   = 2'd2,
        REG_THREE_PLANES = 2'd3
    } cfg_reg_t;

    // Plane numbers
    localparam logic [CHAN_W-1:0] PLANE_FIRST = 2'd0;
    localparam logic [CHAN_W-1:0] PLANE_LAST3 = 2'd2;

    // Decoder sequencer states, one-hot
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } dec_state_t;

endpackage

### sv/pcx_rle_scanline_decoder.sv
// ----------------------------------------------------------------------------
// PCX run-length scanline decoder
// Expands a PCX run-length byte stream into bytes tagged with row, column
// and colour plane, flagging line padding and the end of each frame.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_ready, code_byte) takes one encoded byte
// per transaction. The output channel (out_valid, out_ready and the result
// fields) delivers one decoded byte per transaction from an output register.
// A literal byte appears on the output in the cycle after its transaction.
// A run header produces nothing. The value byte that follows it is repeated
// by one shared emit step, one byte per cycle unless the receiver stalls,
// until its count runs out or the line ends; in_ready stays low meanwhile.
// A run of zero ends at once. The emit step (position counter, line-end and
// frame-end compares) sets the rate: one output byte per cycle while the
// receiver keeps up. The last flag marks the final byte caused by one input
// transaction. When the receiver stalls, the output register holds its
// transaction and the decoder waits; in_ready is low until the register
// can be loaded. Reset clears the position to row 0, plane 0, column 0 and
// loads the register defaults (320 wide, 200 high, 320 line bytes, one
// plane). Configuration written via cfg_write_en, cfg_index and cfg_data
// acts at once; the user must write only with the decoder idle (unchecked).
// ----------------------------------------------------------------------------
module pcx_rle_scanline_decoder
    import pcx_rle_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // Configuration write port
    input  logic              cfg_write_en,
    input  logic [1:0]        cfg_index,
    input  logic [DIM_W-1:0]  cfg_data,
    // Encoded byte input
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] code_byte,
    // Decoded byte output
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] pixel_value,
    output logic [DIM_W-1:0]  column,
    output logic [CHAN_W-1:0] channel,
    output logic [DIM_W-1:0]  row,
    output logic              in_image,
    output logic              frame_end,
    output logic              last
);

    // Configuration registers
    logic [DIM_W-1:0] image_width_reg;
    logic [DIM_W-1:0] image_height_reg;
    logic [DIM_W-1:0] line_bytes_reg;
    logic             three_planes_reg;

    // Decoder state
    dec_state_t        state_reg, state_next;
    logic              run_pending_reg, run_pending_next;
    logic [RUN_W-1:0]  run_length_reg, run_length_next;
    logic [RUN_W-1:0]  count_reg, count_next;
    logic [BYTE_W-1:0] value_reg, value_next;
    logic [DIM_W-1:0]  line_pos_reg, line_pos_next;
    logic [CHAN_W-1:0] plane_reg, plane_next;
    logic [DIM_W-1:0]  row_reg, row_next;

    // Output register
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] pixel_value_reg;
    logic [DIM_W-1:0]  column_reg;
    logic [CHAN_W-1:0] channel_reg;
    logic [DIM_W-1:0]  row_out_reg;
    logic              in_image_reg;
    logic              frame_end_reg;
    logic              last_reg;

    // Emit step signals
    logic              slot_free;
    logic              in_accept;
    logic              emit_go;
    logic [BYTE_W-1:0] emit_value;
    logic              emit_last;
    logic [DIM_W:0]    pos_inc;
    logic [DIM_W:0]    row_inc;
    logic [CHAN_W-1:0] last_plane;
    logic              line_done;
    logic              plane_last;
    logic              row_last;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= 16'd320;
            image_height_reg <= 16'd200;
            line_bytes_reg   <= 16'd320;
            three_planes_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                REG_LINE_BYTES:   line_bytes_reg   <= cfg_data;
                REG_THREE_PLANES: three_planes_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Handshake: the output slot is free when empty or being drained
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && slot_free;
    assign in_accept = in_valid && in_ready;

    // Position compares shared by literals and run repeats
    assign pos_inc    = {1'b0, line_pos_reg} + {{DIM_W{1'b0}}, 1'b1};
    assign row_inc    = {1'b0, row_reg} + {{DIM_W{1'b0}}, 1'b1};
    assign last_plane = three_planes_reg ? PLANE_LAST3 : PLANE_FIRST;
    assign line_done  = pos_inc >= {1'b0, line_bytes_reg};
    assign plane_last = plane_reg >= last_plane;
    assign row_last   = row_inc >= {1'b0, image_height_reg};

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        run_pending_next = run_pending_reg;
        run_length_next  = run_length_reg;
        count_next       = count_reg;
        value_next       = value_reg;
        emit_go          = 1'b0;
        emit_value       = code_byte;
        emit_last        = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (run_pending_reg)
                    begin
                        // Value byte of a run: repeat it, unless the count is zero
                        run_pending_next = 1'b0;
                        run_length_next  = '0;
                        count_next       = run_length_reg & RUN_MASK;
                        value_next       = code_byte;
                        if (run_length_reg != '0)
                        begin
                            state_next = S_RUN;
                        end
                    end
                    else if (code_byte >= RUN_MARK)
                    begin
                        // Run header: arm the run only
                        run_pending_next = 1'b1;
                        run_length_next  = code_byte[RUN_W-1:0] & RUN_MASK;
                    end
                    else
                    begin
                        // Literal byte
                        emit_go = 1'b1;
                    end
                end
            end
            S_RUN:
            begin
                emit_value = value_reg;
                emit_last  = (count_reg == 6'd1) || line_done;
                if (slot_free)
                begin
                    emit_go    = 1'b1;
                    count_next = count_reg - 6'd1;
                    if (emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Position advance on each emitted byte
    always_comb
    begin
        line_pos_next = line_pos_reg;
        plane_next    = plane_reg;
        row_next      = row_reg;
        if (emit_go)
        begin
            if (!line_done)
            begin
                line_pos_next = pos_inc[DIM_W-1:0];
            end
            else
            begin
                line_pos_next = '0;
                if (!plane_last)
                begin
                    plane_next = plane_reg + 2'd1;
                end
                else
                begin
                    plane_next = PLANE_FIRST;
                    row_next   = row_last ? '0 : row_inc[DIM_W-1:0];
                end
            end
        end
    end

    // Output valid flag
    always_comb
    begin
        if (emit_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            run_pending_reg <= 1'b0;
            run_length_reg  <= '0;
            count_reg       <= '0;
            line_pos_reg    <= '0;
            plane_reg       <= '0;
            row_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            run_pending_reg <= run_pending_next;
            run_length_reg  <= run_length_next;
            count_reg       <= count_next;
            line_pos_reg    <= line_pos_next;
            plane_reg       <= plane_next;
            row_reg         <= row_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        if (emit_go)
        begin
            pixel_value_reg <= emit_value;
            column_reg      <= line_pos_reg;
            channel_reg     <= plane_reg;
            row_out_reg     <= row_reg;
            in_image_reg    <= line_pos_reg < image_width_reg;
            frame_end_reg   <= line_done && plane_last && row_last;
            last_reg        <= emit_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_value = pixel_value_reg;
    assign column      = column_reg;
    assign channel     = channel_reg;
    assign row         = row_out_reg;
    assign in_image    = in_image_reg;
    assign frame_end   = frame_end_reg;
    assign last        = last_reg;

    // Checks
    // A run in progress always has repeats left.
    a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (count_reg != '0))
        else $error("run state entered with zero repeats");

    // The frame end byte always completes the input transaction's results.
    a_frame_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && frame_end_reg) |-> last_reg)
        else $error("frame end byte not marked last");

    // The plane counter never reaches an unused plane number.
    a_plane_range: assert property (@(posedge clk) disable iff (!rst_n)
        plane_reg != 2'd3)
        else $error("plane counter out of range");

    // No input is taken while a run is still being repeated.
    a_no_accept_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> !in_ready)
        else $error("input accepted during a run");

    // A run header never produces a result.
    a_header_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !run_pending_reg && (code_byte >= RUN_MARK)) |-> !emit_go)
        else $error("run header produced a result");

endmodule

### tb/pcx_rle_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PCX run-length decoder checker
// Watches the configuration port and both channels of the scanline decoder.
// It keeps its own copy of the registers and of the decode position, works
// out the pixels that each accepted code byte must produce, and compares
// every output transaction field by field with the oldest pixel still due.
// ----------------------------------------------------------------------------
module pcx_rle_checker
    import pcx_rle_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic [1:0]        cfg_index,
    input  logic [DIM_W-1:0]  cfg_data,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [BYTE_W-1:0] code_byte,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [BYTE_W-1:0] pixel_value,
    input  logic [DIM_W-1:0]  column,
    input  logic [CHAN_W-1:0] channel,
    input  logic [DIM_W-1:0]  row,
    input  logic              in_image,
    input  logic              frame_end,
    input  logic              last,
    output int                mismatches,
    output int                pixels_due
);

    typedef struct packed {
        logic [BYTE_W-1:0] pixel_value;
        logic [DIM_W-1:0]  column;
        logic [CHAN_W-1:0] channel;
        logic [DIM_W-1:0]  row;
        logic              in_image;
        logic              frame_end;
        logic              last;
    } pixel_t;

    // Register copies
    logic [DIM_W-1:0]  cfg_width        = 16'd320;
    logic [DIM_W-1:0]  cfg_height       = 16'd200;
    logic [DIM_W-1:0]  cfg_line_bytes   = 16'd320;
    logic              cfg_three_planes = 1'b0;

    // Decode position and run state
    logic              run_armed = 1'b0;
    logic [RUN_W-1:0]  run_count = '0;
    logic [DIM_W-1:0]  col_pos   = '0;
    logic [CHAN_W-1:0] plane_idx = '0;
    logic [DIM_W-1:0]  row_idx   = '0;

    pixel_t expected_pixels[$];

    initial
    begin
        mismatches = 0;
        pixels_due = 0;
    end

    // Places one byte at the current position and advances it. The line ends
    // once the next column reaches the line length, which also covers a
    // position left beyond a line length that has just been shortened.
    task automatic emit_pixel(input logic [BYTE_W-1:0] value, output pixel_t px,
                              output bit line_done);
        logic [DIM_W:0] next_col;
        logic [DIM_W:0] next_row;
        bit             plane_last;
        bit             row_last;
        next_col   = {1'b0, col_pos} + 1'b1;
        next_row   = {1'b0, row_idx} + 1'b1;
        line_done  = next_col >= {1'b0, cfg_line_bytes};
        plane_last = plane_idx >= (cfg_three_planes ? PLANE_LAST3 : PLANE_FIRST);
        row_last   = next_row >= {1'b0, cfg_height};

        px.pixel_value = value;
        px.column      = col_pos;
        px.channel     = plane_idx;
        px.row         = row_idx;
        px.in_image    = col_pos < cfg_width;
        px.frame_end   = line_done && plane_last && row_last;
        px.last        = 1'b0;

        if (!line_done)
        begin
            col_pos = next_col[DIM_W-1:0];
        end
        else
        begin
            col_pos = '0;
            if (!plane_last)
            begin
                plane_idx = plane_idx + 1'b1;
            end
            else
            begin
                plane_idx = PLANE_FIRST;
                row_idx   = row_last ? '0 : next_row[DIM_W-1:0];
            end
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches = mismatches + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        pixel_t      px;
        pixel_t      want;
        bit          ended;
        int unsigned repeats;
        if (!rst_n)
        begin
            cfg_width        = 16'd320;
            cfg_height       = 16'd200;
            cfg_line_bytes   = 16'd320;
            cfg_three_planes = 1'b0;
            run_armed        = 1'b0;
            run_count        = '0;
            col_pos          = '0;
            plane_idx        = PLANE_FIRST;
            row_idx          = '0;
            expected_pixels.delete();
            pixels_due       = 0;
        end
        else
        begin
            // Register writes take effect at once and leave the position alone.
            if (cfg_write_en)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_IMAGE_WIDTH:  cfg_width        = cfg_data;
                    REG_IMAGE_HEIGHT: cfg_height       = cfg_data;
                    REG_LINE_BYTES:   cfg_line_bytes   = cfg_data;
                    REG_THREE_PLANES: cfg_three_planes = cfg_data[0];
                    default:          ;
                endcase
            end

            // Input transaction: a run header only arms the run; the byte after
            // it repeats until the count runs out or the plane line ends.
            if (in_valid && in_ready)
            begin
                if (run_armed)
                begin
                    repeats   = run_count;
                    run_armed = 1'b0;
                    run_count = '0;
                    ended     = 1'b0;
                    while (repeats > 0 && !ended)
                    begin
                        emit_pixel(code_byte, px, ended);
                        repeats = repeats - 1;
                        if (repeats == 0 || ended)
                        begin
                            px.last = 1'b1;
                        end
                        expected_pixels.push_back(px);
                    end
                end
                else if (code_byte >= RUN_MARK)
                begin
                    run_armed = 1'b1;
                    run_count = code_byte[RUN_W-1:0] & RUN_MASK;
                end
                else
                begin
                    emit_pixel(code_byte, px, ended);
                    px.last = 1'b1;
                    expected_pixels.push_back(px);
                end
            end

            // Output transaction against the oldest pixel still due
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("unexpected output transaction: value %0d row %0d column %0d",
                           pixel_value, row, column);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_field("pixel_value", want.pixel_value, pixel_value);
                    check_field("column", want.column, column);
                    check_field("channel", want.channel, channel);
                    check_field("row", want.row, row);
                    check_field("in_image", want.in_image, in_image);
                    check_field("frame_end", want.frame_end, frame_end);
                    check_field("last", want.last, last);
                end
            end

            pixels_due = expected_pixels.size();
        end
    end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PCX run-length decoder testbench
// Drives code bytes into the scanline decoder with random gaps and output
// stalls, stepping through several register settings between bursts. A short
// directed stream covers literals, run headers, zero runs, full runs and runs
// cut at the line end; random literal and run streams follow. The checker
// beside the decoder predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import pcx_rle_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              cfg_write_en;
    logic [1:0]        cfg_index;
    logic [DIM_W-1:0]  cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic [BYTE_W-1:0] code_byte;
    logic              out_valid;
    logic              out_ready;
    logic [BYTE_W-1:0] pixel_value;
    logic [DIM_W-1:0]  column;
    logic [CHAN_W-1:0] channel;
    logic [DIM_W-1:0]  row;
    logic              in_image;
    logic              frame_end;
    logic              last;

    int mismatches;
    int pixels_due;
    bit calm;

    pcx_rle_scanline_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .code_byte    (code_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_value  (pixel_value),
        .column       (column),
        .channel      (channel),
        .row          (row),
        .in_image     (in_image),
        .frame_end    (frame_end),
        .last         (last)
    );

    pcx_rle_checker check_unit (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .code_byte    (code_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_value  (pixel_value),
        .column       (column),
        .channel      (channel),
        .row          (row),
        .in_image     (in_image),
        .frame_end    (frame_end),
        .last         (last),
        .mismatches   (mismatches),
        .pixels_due   (pixels_due)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit, well above the slowest correct run
    initial
    begin
        #20_000_000;
        $display("tb: done, errors");
        $finish;
    end

    // Idle cycles before the next transaction on either side
    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 15);
    endfunction

    // Receiver: holds out_ready low for a random gap before each transaction.
    initial
    begin : receiver
        int gap;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    // Presents one code byte after a random gap and holds it until taken.
    task automatic send_byte(input logic [BYTE_W-1:0] value);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        code_byte <= value;
        do @(posedge clk); while (in_ready !== 1'b1);
    endtask

    // Drops valid, waits for every pixel due, then lets a zero run finish.
    task automatic settle();
        in_valid <= 1'b0;
        do @(negedge clk); while (pixels_due != 0);
        repeat (8) @(posedge clk);
    endtask

    // Writes all four registers on consecutive edges.
    task automatic write_config(input logic [DIM_W-1:0] width,
                                input logic [DIM_W-1:0] height,
                                input logic [DIM_W-1:0] lbytes,
                                input logic             planes);
        cfg_write_en <= 1'b1;
        cfg_index    <= REG_IMAGE_WIDTH;
        cfg_data     <= width;
        @(posedge clk);
        cfg_index    <= REG_IMAGE_HEIGHT;
        cfg_data     <= height;
        @(posedge clk);
        cfg_index    <= REG_LINE_BYTES;
        cfg_data     <= lbytes;
        @(posedge clk);
        cfg_index    <= REG_THREE_PLANES;
        cfg_data     <= {{(DIM_W-1){1'b0}}, planes};
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    initial
    begin : stimulus
        int               phase;
        int               sent;
        logic [RUN_W-1:0] count;

        rst_n        <= 1'b0;
        cfg_write_en <= 1'b0;
        cfg_index    <= REG_IMAGE_WIDTH;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        code_byte    <= '0;
        calm          = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset register values: literal extremes, a zero run, a full run,
        // a run of a value that looks like a header, short runs.
        send_byte(8'h00);
        send_byte(8'hBF);
        send_byte(RUN_MARK);
        send_byte(8'h7E);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hC3);
        send_byte(8'hC0);
        send_byte(8'hC2);
        send_byte(8'h00);
        send_byte(8'h55);
        send_byte(8'hAA);
        settle();

        for (phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: write_config(16'd4, 16'd2, 16'd6, 1'b1);
                1: write_config(16'd7, 16'd3, 16'd8, 1'b0);
                2: write_config(16'd0, 16'd0, 16'd0, 1'b1);
                3: write_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
                4: write_config(16'd1, 16'd1, 16'd1, 1'b0);
                5: write_config(16'd12, 16'd2, 16'd16, 1'b1);
                default:
                    write_config(16'($urandom_range(1, 20)), 16'($urandom_range(1, 4)),
                                 16'($urandom_range(1, 24)), 1'($urandom_range(0, 1)));
            endcase

            if (phase == 0)
            begin
                // The stale column lies past the new line length: one byte,
                // then the line ends. Then a run cut at the line end, and
                // whole lines up to the end of the frame.
                send_byte(8'h01);
                send_byte(8'hCA);
                send_byte(8'h12);
                send_byte(8'h02);
                send_byte(8'hC5);
                send_byte(8'h03);
                send_byte(8'hC6);
                send_byte(8'h34);
                send_byte(8'hFF);
                send_byte(8'h80);
                send_byte(8'hC6);
                send_byte(8'h81);
                send_byte(8'hC6);
                send_byte(8'h82);
            end

            // Random literals and runs; runs are mostly short so that lines
            // and frames turn over often.
            calm = (phase % 3 == 2);
            sent = 0;
            while (sent < 38)
            begin
                if ($urandom_range(0, 29) == 0)
                begin
                    calm = !calm;
                end
                if ($urandom_range(0, 9) < 4)
                begin
                    send_byte(8'($urandom_range(0, 8'hBF)));
                    sent = sent + 1;
                end
                else
                begin
                    count = ($urandom_range(0, 2) == 0) ? 6'($urandom_range(0, 63))
                                                        : 6'($urandom_range(0, 8));
                    send_byte(RUN_MARK | {2'b00, count});
                    send_byte(8'($urandom_range(0, 255)));
                    sent = sent + 2;
                end
            end
            settle();
        end

        if (mismatches == 0)
        begin
            $display("tb: done, clean");
        end
        else
        begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
